// ===== hw/rtl/sbqp_pkg.sv =====
// ----------------------------------------------------------------------------
// sbqp_pkg
// Shared types, character codes and helper functions for the SMTP body
// quoted-printable converter.
// ----------------------------------------------------------------------------
package sbqp_pkg;

    localparam int BYTE_W   = 8;
    localparam int MAX_OUT  = 6;
    localparam int CNT_W    = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CONVERT_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNKING_ON  = 1'd1;

    // conversion modes
    localparam logic [1:0] MODE_PASS      = 2'd0;
    localparam logic [1:0] MODE_QP_ENC    = 2'd1;
    localparam logic [1:0] MODE_QP_DEC    = 2'd2;
    localparam logic [1:0] MODE_QP_ENC_UC = 2'd3;

    // character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_CTRL_LIM  = 8'd32;
    localparam logic [7:0] CH_PRINT_MAX = 8'd126;

    localparam logic signed [7:0] COL_START     = -8'sd1;
    localparam logic signed [8:0] COL_MAX       = 9'sd127;
    localparam logic signed [7:0] COL_SOFT_BRK  = 8'sd70;

    typedef struct packed {
        logic signed [7:0] col;
        logic [1:0]        esc_left;
        logic [7:0]        esc_val;
        logic              drop;
    } state_t;

    typedef struct packed {
        logic [MAX_OUT-1:0][BYTE_W-1:0] bytes;
        logic [CNT_W-1:0]               count;
    } result_t;

    // column advance, saturating at 127
    function automatic logic signed [7:0] col_add(input logic signed [7:0] c,
                                                  input logic [1:0] k);
        logic signed [8:0] sum;
        sum = {c[7], c} + $signed({7'd0, k});
        if (sum > COL_MAX) begin
            return COL_MAX[7:0];
        end
        return sum[7:0];
    endfunction

    // upper-case hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return 8'h30 + {4'd0, nib};
        end
        return 8'h37 + {4'd0, nib};
    endfunction

    // {valid, nibble} of a hex character, either case
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
            return {1'b1, d[3:0]};
        end
        if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
            return {1'b1, d[3:0]};
        end
        if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

endpackage

// ===== hw/rtl/sbqp_core.sv =====
// ----------------------------------------------------------------------------
// sbqp_core
// Line state register and the single-pass conversion of one byte into its
// list of output bytes.
// ----------------------------------------------------------------------------
module sbqp_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [1:0]           convert_mode,
    input  logic                 chunking_on,
    input  logic [7:0]           data_byte,
    input  logic                 line_final,
    input  logic                 line_penultimate,
    input  logic                 consume,
    output sbqp_pkg::result_t    result
);

    sbqp_pkg::state_t state_reg;
    sbqp_pkg::state_t state_next;

    always_comb begin
        logic [7:0]              cc;
        logic                    pass;
        logic                    esc;
        logic                    near;
        logic                    blank;
        logic                    ws;
        logic [4:0]              hn;
        logic [7:0]              ev;
        logic [sbqp_pkg::CNT_W-1:0] n;

        state_next   = state_reg;
        result.bytes = '0;
        n     = '0;
        cc    = data_byte;
        pass  = 1'b0;
        esc   = 1'b0;
        ev    = 8'd0;
        hn    = 5'd0;
        near  = line_final | line_penultimate;
        blank = (data_byte == sbqp_pkg::CH_SPACE) || (data_byte == sbqp_pkg::CH_TAB);
        ws    = blank || (data_byte == sbqp_pkg::CH_LF) || (data_byte == sbqp_pkg::CH_CR);

        if (state_reg.drop) begin
            pass = 1'b0;
        end else if (convert_mode == sbqp_pkg::MODE_QP_DEC) begin
            if (state_reg.esc_left == 2'd0) begin
                state_next.col = sbqp_pkg::col_add(state_reg.col, 2'd1);
                if (data_byte == sbqp_pkg::CH_EQ) begin
                    state_next.esc_val  = 8'd0;
                    state_next.esc_left = 2'd2;
                end else begin
                    pass = 1'b1;
                end
            end else if (ws) begin
                // soft break: rest of the line is discarded
                state_next.col  = sbqp_pkg::col_add(state_reg.col, 2'd1);
                state_next.drop = 1'b1;
            end else begin
                hn = sbqp_pkg::hex_nibble(data_byte);
                ev = hn[4] ? {state_reg.esc_val[3:0], hn[3:0]} : state_reg.esc_val;
                state_next.esc_val  = ev;
                state_next.esc_left = state_reg.esc_left - 2'd1;
                if (state_reg.esc_left == 2'd1) begin
                    cc   = ev;
                    pass = 1'b1;
                end
            end
        end else begin
            state_next.col = sbqp_pkg::col_add(state_reg.col, 2'd1);
            if (convert_mode == sbqp_pkg::MODE_QP_ENC ||
                convert_mode == sbqp_pkg::MODE_QP_ENC_UC) begin
                if (state_next.col > sbqp_pkg::COL_SOFT_BRK &&
                    data_byte != sbqp_pkg::CH_LF) begin
                    result.bytes[n] = sbqp_pkg::CH_EQ; n = n + 1'b1;
                    result.bytes[n] = sbqp_pkg::CH_CR; n = n + 1'b1;
                    result.bytes[n] = sbqp_pkg::CH_LF; n = n + 1'b1;
                    state_next.col = 8'sd0;
                end
                if (near && blank) begin
                    esc = 1'b1;
                end else if (data_byte == sbqp_pkg::CH_EQ ||
                             data_byte > sbqp_pkg::CH_PRINT_MAX ||
                             (state_next.col == 8'sd0 &&
                              (data_byte == sbqp_pkg::CH_F ||
                               data_byte == sbqp_pkg::CH_DOT)) ||
                             (data_byte != sbqp_pkg::CH_LF &&
                              data_byte != sbqp_pkg::CH_TAB &&
                              data_byte < sbqp_pkg::CH_CTRL_LIM)) begin
                    esc = 1'b1;
                end
                if (esc) begin
                    result.bytes[n] = sbqp_pkg::CH_EQ; n = n + 1'b1;
                    result.bytes[n] = sbqp_pkg::hex_char(data_byte[7:4]); n = n + 1'b1;
                    result.bytes[n] = sbqp_pkg::hex_char(data_byte[3:0]); n = n + 1'b1;
                    state_next.col = sbqp_pkg::col_add(state_next.col, 2'd2);
                end else begin
                    pass = 1'b1;
                end
            end else begin
                pass = 1'b1;
            end
        end

        if (pass) begin
            if (state_next.col == 8'sd0 && cc == sbqp_pkg::CH_DOT && !chunking_on) begin
                result.bytes[n] = cc; n = n + 1'b1;
            end
            if (cc == sbqp_pkg::CH_LF) begin
                result.bytes[n] = sbqp_pkg::CH_CR; n = n + 1'b1;
                state_next.col = sbqp_pkg::COL_START;
            end
            result.bytes[n] = cc; n = n + 1'b1;
        end

        if (line_final) begin
            state_next.esc_left = 2'd0;
            state_next.esc_val  = 8'd0;
            state_next.drop     = 1'b0;
        end

        result.count = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.col      <= sbqp_pkg::COL_START;
            state_reg.esc_left <= 2'd0;
            state_reg.esc_val  <= 8'd0;
            state_reg.drop     <= 1'b0;
        end else if (consume) begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/sbqp_out_buf.sv =====
// ----------------------------------------------------------------------------
// sbqp_out_buf
// Result register holding the byte list of one request and draining it one
// byte per accepted output transfer.
// ----------------------------------------------------------------------------
module sbqp_out_buf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  sbqp_pkg::result_t    result,
    output logic                 free,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_out_byte,
    output logic                 m_run_end
);

    logic [sbqp_pkg::MAX_OUT-1:0][7:0] bytes_reg;
    logic [sbqp_pkg::CNT_W-1:0]        cnt_reg;
    logic [sbqp_pkg::CNT_W-1:0]        idx_reg;
    logic                              valid_reg;
    logic                              last;

    assign last       = (idx_reg == cnt_reg - 1'b1);
    assign m_valid    = valid_reg;
    assign m_out_byte = bytes_reg[idx_reg];
    assign m_run_end  = last;
    assign free       = !valid_reg || (m_ready && last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
            cnt_reg   <= '0;
        end else if (load) begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
            cnt_reg   <= result.count;
        end else if (valid_reg && m_ready) begin
            if (last) begin
                valid_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bytes_reg <= result.bytes;
        end
    end

endmodule

// ===== hw/rtl/smtp_body_qp_converter.sv =====
// ----------------------------------------------------------------------------
// smtp_body_qp_converter
// SMTP body byte converter: pass-through, QP encode/decode, CRLF and dot
// stuffing.
// ----------------------------------------------------------------------------
// Takes one body byte per request and produces zero to six bytes, the last
// one marked by m_run_end. A byte is registered on entry, converted
// combinationally and its output list parked in a result register that drains
// one byte per cycle while m_ready is high; a byte with no output retires
// without waiting for it. Input rate is one byte per cycle while each byte
// yields at most one output and m_ready stays high; expanding bytes (escapes,
// soft breaks, CRLF, doubled dots) hold the next byte until their output drains.
// Configuration writes must be made only while the block is idle.
// ----------------------------------------------------------------------------
module smtp_body_qp_converter (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [sbqp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sbqp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_data_byte,
    input  logic                               s_line_final,
    input  logic                               s_line_penultimate,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [7:0]                         m_out_byte,
    output logic                               m_run_end
);

    logic [1:0]        mode_reg;
    logic              chunk_reg;
    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_final_reg;
    logic              in_penult_reg;
    logic              consume;
    logic              load;
    logic              free;
    sbqp_pkg::result_t result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= sbqp_pkg::MODE_PASS;
            chunk_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                sbqp_pkg::REG_CONVERT_MODE: mode_reg  <= cfg_data[1:0];
                sbqp_pkg::REG_CHUNKING_ON:  chunk_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // bytes with no output retire without waiting for the result register
    assign consume = in_valid_reg && ((result.count == '0) || free);
    assign load    = in_valid_reg && (result.count != '0) && free;
    assign s_ready = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg   <= s_data_byte;
            in_final_reg  <= s_line_final;
            in_penult_reg <= s_line_penultimate;
        end
    end

    sbqp_core u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .convert_mode     (mode_reg),
        .chunking_on      (chunk_reg),
        .data_byte        (in_byte_reg),
        .line_final       (in_final_reg),
        .line_penultimate (in_penult_reg),
        .consume          (consume),
        .result           (result)
    );

    sbqp_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (load),
        .result     (result),
        .free       (free),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_run_end  (m_run_end)
    );

endmodule
